[rtl/subq_pkg.sv]
// Package with the item types, register indexes and reset values of the subchannel-Q checker.
package subq_pkg;

  // One decoded subchannel-Q frame.
  typedef struct packed {
    logic [3:0]         ctl;
    logic [3:0]         adr;
    logic [6:0]         track;
    logic [6:0]         index_no;
    logic [18:0]        rel_time;
    logic [18:0]        abs_time;
    logic [7:0]         msf_min_bcd;
    logic [7:0]         msf_sec_bcd;
    logic [7:0]         msf_frame_bcd;
    logic signed [19:0] sector_lba;
    logic [3:0]         end_ctl;
  } subq_in_t;

  // Verdict for one frame.
  typedef struct packed {
    logic abs_time_ok;
    logic control_ok;
    logic index_ok;
    logic track_ok;
    logic prev_index_doubtful;
    logic older_index_doubtful;
    logic prev_track_doubtful;
  } subq_out_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgFirstTrack = 2'd0;
  localparam logic [1:0] CfgLastTrack  = 2'd1;
  localparam logic [1:0] CfgIndexLimit = 2'd2;

  // Configuration reset values.
  localparam logic [6:0] FirstTrackRst = 7'd1;
  localparam logic [6:0] LastTrackRst  = 7'd99;
  localparam logic [6:0] IndexLimitRst = 7'd100;

  // Offset between MSF time and logical block address.
  localparam int unsigned LbaOffset = 150;

  // Address mode codes used in address mode checks.
  localparam logic [3:0] AdrCurrentPos = 4'd1;

  // Decodes a BCD byte with each nibble weighted as it stands.
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // Control nibble values that may appear on a disc.
  function automatic logic control_allowed(input logic [3:0] c);
    logic ok;
    unique case (c)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[rtl/subq_sequence_checker.sv]
// Top level of the subchannel-Q sequence checker: input register, compare logic, result register.
//
// The checker takes one decoded subchannel-Q frame per item and answers one verdict item
// per frame: absolute time, control, index and track validity plus three doubtful flags
// about the frames before it. Every frame is shifted into a two-frame history whatever its
// verdict. An item passes an input register and then a result register before its verdict is
// offered; a new item is accepted every cycle while the result side
// keeps taking verdicts, the rate being set by the single-cycle compare logic between the
// two registers. Configuration registers are written through a port that is always ready
// and take effect for items checked after the write; a write to an unused index is ignored.
module subq_sequence_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  subq_pkg::subq_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output subq_pkg::subq_out_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i
);
  import subq_pkg::*;

  // Configuration registers.
  logic [6:0] first_track_q, last_track_q, index_limit_q;

  // Pipeline registers.
  logic       s1_valid_q, out_valid_q;
  subq_in_t   s1_q;
  subq_out_t  out_q, res_d;

  // Frame history.
  logic [3:0]  prev_ctl_q, older_ctl_q;
  logic [6:0]  prev_track_q, older_track_q;
  logic [6:0]  prev_index_q, older_index_q;
  logic [18:0] prev_rel_time_q, older_rel_time_q;
  logic [18:0] prev_abs_time_q;

  // Handshake.
  logic advance, in_accept;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_track_q <= FirstTrackRst;
      last_track_q  <= LastTrackRst;
      index_limit_q <= IndexLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFirstTrack: first_track_q <= cfg_data_i;
        CfgLastTrack:  last_track_q  <= cfg_data_i;
        CfgIndexLimit: index_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Widened copies of the current frame and the history.
  logic [7:0]  trk, idx, pt, pi, ot, oi, pt1, pi1, oi_idx1;
  logic [19:0] rel, pr1, orl2, abst, pa1;

  assign trk     = {1'b0, s1_q.track};
  assign idx     = {1'b0, s1_q.index_no};
  assign pt      = {1'b0, prev_track_q};
  assign pi      = {1'b0, prev_index_q};
  assign ot      = {1'b0, older_track_q};
  assign oi      = {1'b0, older_index_q};
  assign pt1     = pt + 8'd1;
  assign pi1     = pi + 8'd1;
  assign oi_idx1 = idx + 8'd1;
  assign rel     = {1'b0, s1_q.rel_time};
  assign abst    = {1'b0, s1_q.abs_time};
  assign pr1     = {1'b0, prev_rel_time_q} + 20'd1;
  assign orl2    = {1'b0, older_rel_time_q} + 20'd2;
  assign pa1     = {1'b0, prev_abs_time_q} + 20'd1;

  // MSF to block address: minutes * 4500 + seconds * 75 + frames - 150.
  logic [7:0]         mm, ss, ff;
  logic signed [21:0] msf_lba;

  assign mm = bcd_value(s1_q.msf_min_bcd);
  assign ss = bcd_value(s1_q.msf_sec_bcd);
  assign ff = bcd_value(s1_q.msf_frame_bcd);
  assign msf_lba = $signed({14'd0, mm}) * 22'sd4500 + $signed({14'd0, ss}) * 22'sd75
                 + $signed({14'd0, ff}) - 22'(LbaOffset);

  // Verdict logic.
  always_comb begin
    logic ctl_chg;
    res_d = '0;

    // Absolute time matches the block address and advanced by one frame.
    res_d.abs_time_ok = (msf_lba == 22'(s1_q.sector_lba)) && (pa1 == abst);

    // Control nibble and its change.
    ctl_chg = 1'b1;
    if (s1_q.adr == AdrCurrentPos) begin
      if (pt1 == trk) begin
        ctl_chg = !(pr1 == rel);
      end else if (pt == trk && pi == idx) begin
        ctl_chg = !(pr1 == rel);
      end
    end
    if (older_ctl_q == s1_q.ctl) begin
      ctl_chg = 1'b1;
    end
    priority if (!control_allowed(s1_q.ctl)) begin
      res_d.control_ok = 1'b0;
    end else if (prev_ctl_q == s1_q.ctl) begin
      res_d.control_ok = 1'b1;
    end else if (s1_q.ctl != s1_q.end_ctl && s1_q.ctl != 4'd0) begin
      res_d.control_ok = 1'b0;
    end else begin
      res_d.control_ok = ctl_chg;
    end

    // Index transition; a previous index of zero never matches index plus one.
    res_d.index_ok = 1'b1;
    if (pi != idx) begin
      priority if (pi1 < idx) begin
        res_d.index_ok = 1'b0;
      end else if ({1'b0, index_limit_q} < idx) begin
        res_d.index_ok = 1'b0;
      end else begin
        res_d.index_ok = (pi == 8'd0 && idx == 8'd1 && rel == 20'd0)
                      || ((idx == 8'd0 || idx == 8'd1) && pt1 == trk
                          && rel < {1'b0, prev_rel_time_q})
                      || (pi1 == idx && pr1 == rel);
        if (oi == idx) begin
          res_d.index_ok = 1'b1;
          res_d.prev_index_doubtful = (pi == oi_idx1);
        end
      end
    end else begin
      res_d.older_index_doubtful = (oi == oi_idx1) && (ot + 8'd1 != trk);
    end

    // Track number range and transition.
    res_d.track_ok = 1'b1;
    priority if (s1_q.track < first_track_q || last_track_q < s1_q.track) begin
      res_d.track_ok = 1'b0;
    end else if (pt != trk) begin
      priority if (pt + 8'd2 <= trk) begin
        res_d.track_ok = 1'b0;
      end else if (pt > trk) begin
        if (ot == trk) begin
          res_d.prev_track_doubtful = 1'b1;
        end else begin
          res_d.track_ok = 1'b0;
        end
      end else begin
        // Only a step of one track remains here.
        if (pr1 <= rel || orl2 <= rel) begin
          res_d.track_ok = 1'b0;
        end
        if (ot == trk) begin
          res_d.track_ok = 1'b1;
        end
      end
    end
  end

  // Pipeline control and history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      prev_ctl_q       <= '0;
      prev_track_q     <= '0;
      prev_index_q     <= '0;
      prev_rel_time_q  <= '0;
      prev_abs_time_q  <= '0;
      older_ctl_q      <= '0;
      older_track_q    <= '0;
      older_index_q    <= '0;
      older_rel_time_q <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      // The input register also fills while it is empty and the result side waits.
      if (advance || !s1_valid_q) begin
        s1_valid_q <= in_accept;
      end
      if (advance && s1_valid_q) begin
        older_ctl_q      <= prev_ctl_q;
        older_track_q    <= prev_track_q;
        older_index_q    <= prev_index_q;
        older_rel_time_q <= prev_rel_time_q;
        prev_ctl_q       <= s1_q.ctl;
        prev_track_q     <= s1_q.track;
        prev_index_q     <= s1_q.index_no;
        prev_rel_time_q  <= s1_q.rel_time;
        prev_abs_time_q  <= s1_q.abs_time;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_item_i;
    end
    if (advance && s1_valid_q) begin
      out_q <= res_d;
    end
  end

endmodule

[rtl/subq_sequence_checker_sva.sv]
// Port checker for the subchannel-Q sequence checker and its bind statement.
module subq_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                cfg_ready_o
);
  import subq_pkg::*;

  // A stalled verdict stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("verdict dropped while stalled");

  // With no verdict waiting the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // An accepted item has its verdict offered from the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted item produced no verdict");

  // The configuration port is always ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind subq_sequence_checker subq_sva u_subq_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cfg_ready_o (cfg_ready_o)
);

[sim/subq_sequence_checker_tb.sv]
// Self-checking testbench for the subchannel-Q sequence checker, with random flow control.
module subq_sequence_checker_tb;
  import subq_pkg::*;

  localparam int Phases       = 8;
  localparam int FirstItems   = 95;
  localparam int PhaseItems   = 140;
  localparam int MsfOffset    = int'(LbaOffset);
  localparam int LastPos      = 449999;
  localparam int ReportCap    = 200;
  localparam int HoldCycles   = 120;
  // Bit c is set when control nibble c may appear on a disc.
  localparam logic [15:0] CtlAllowed = 16'h0F5F;
  // Register index with no register behind it.
  localparam logic [1:0]  CfgUnused  = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  subq_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  subq_out_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data  = '0;

  // Register copies used for prediction.
  logic [6:0] cfg_first = FirstTrackRst;
  logic [6:0] cfg_last  = LastTrackRst;
  logic [6:0] cfg_limit = IndexLimitRst;

  // Two-frame history as the checker should hold it.
  int last_ctl, last_trk, last_idx, last_rel, last_abs;
  int prior_ctl, prior_trk, prior_idx, prior_rel;

  // Frames waiting to be offered and verdicts waiting to come out.
  subq_in_t  frames_to_send [$];
  subq_out_t verdicts_due   [$];

  // Position of the simulated pickup on the disc.
  int walk_pos, walk_trk, walk_idx, walk_rel, walk_ctl, walk_endc;
  subq_in_t last_frame = '0;

  bit        quiet_phase = 1'b0;
  int        send_gap, stall_left, hold_left;
  bit        held_off;
  int        sent, checked, errors;
  int        flag_hits [7];
  subq_out_t predicted, awaited;

  logic [6:0] first_by_phase [Phases] = '{7'd1, 7'd0, 7'd0, 7'd99, 7'd40, 7'd127, 7'd1, 7'd1};
  logic [6:0] last_by_phase  [Phases] = '{7'd99, 7'd127, 7'd0, 7'd99, 7'd60, 7'd0, 7'd99, 7'd99};
  logic [6:0] limit_by_phase [Phases] = '{7'd100, 7'd127, 7'd0, 7'd99, 7'd3, 7'd127, 7'd100,
                                          7'd100};

  // Verdict field names by bit position, lowest bit first.
  string verdict_names [7] = '{"prev_track_doubtful", "older_index_doubtful",
                               "prev_index_doubtful", "track_ok", "index_ok",
                               "control_ok", "abs_time_ok"};

  subq_sequence_checker i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int bcd_weight(logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  // Expected verdict for one frame against the current history and registers.
  function automatic subq_out_t judge_frame(subq_in_t f);
    subq_out_t v;
    int ctl, trk, idx, rel, tabs, endc, lba, msf;
    ctl  = int'(f.ctl);
    trk  = int'(f.track);
    idx  = int'(f.index_no);
    rel  = int'(f.rel_time);
    tabs = int'(f.abs_time);
    endc = int'(f.end_ctl);
    lba  = f.sector_lba;
    msf  = (bcd_weight(f.msf_min_bcd) * 60 + bcd_weight(f.msf_sec_bcd)) * 75
           + bcd_weight(f.msf_frame_bcd) - MsfOffset;
    v = '0;

    // Absolute time must match the LBA and follow the previous frame.
    v.abs_time_ok = (lba == msf) && (last_abs + 1 == tabs);

    // A control change is plausible only toward the end value or zero.
    if (!CtlAllowed[f.ctl]) begin
      v.control_ok = 1'b0;
    end else begin
      v.control_ok = 1'b1;
      if (last_ctl != ctl) begin
        if (ctl != endc && ctl != 0) begin
          v.control_ok = 1'b0;
        end else begin
          if (f.adr == AdrCurrentPos) begin
            if (last_trk + 1 == trk) begin
              v.control_ok = (last_rel + 1 != rel);
            end else if (last_trk == trk && last_idx == idx) begin
              v.control_ok = (last_rel + 1 != rel);
            end
          end
          if (prior_ctl == ctl) v.control_ok = 1'b1;
        end
      end
    end

    // Index transitions; the minus-one compares are signed.
    v.index_ok = 1'b1;
    if (last_idx != idx) begin
      if (last_idx + 1 < idx || int'(cfg_limit) < idx) begin
        v.index_ok = 1'b0;
      end else begin
        v.index_ok = (last_idx == 0 && idx == 1 && rel == 0)
                  || ((idx == 0 || idx == 1) && last_trk + 1 == trk && rel < last_rel)
                  || (last_idx + 1 == idx && last_rel + 1 == rel);
        if (prior_idx == idx) begin
          v.index_ok = 1'b1;
          v.prev_index_doubtful = (last_idx - 1 == idx);
        end
      end
    end else begin
      v.older_index_doubtful = (prior_idx - 1 == idx) && (prior_trk + 1 != trk);
    end

    // Track number range and step.
    v.track_ok = 1'b1;
    if (trk < int'(cfg_first) || int'(cfg_last) < trk) begin
      v.track_ok = 1'b0;
    end else if (last_trk != trk) begin
      if (last_trk + 2 <= trk) begin
        v.track_ok = 1'b0;
      end else if (last_trk > trk) begin
        if (prior_trk == trk) v.prev_track_doubtful = 1'b1;
        else v.track_ok = 1'b0;
      end else begin
        if (last_trk + 1 == trk && (last_rel + 1 <= rel || prior_rel + 2 <= rel)) begin
          v.track_ok = 1'b0;
        end
        if (prior_trk == trk) v.track_ok = 1'b1;
      end
    end
    return v;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 50);
  endfunction

  // Consistent frame at the current pickup position.
  function automatic subq_in_t walker_frame();
    subq_in_t f;
    f.ctl           = 4'(walk_ctl);
    f.adr           = AdrCurrentPos;
    f.track         = 7'(walk_trk);
    f.index_no      = 7'(walk_idx);
    f.rel_time      = 19'(walk_rel);
    f.abs_time      = 19'(walk_pos);
    f.msf_min_bcd   = to_bcd(walk_pos / 4500);
    f.msf_sec_bcd   = to_bcd((walk_pos / 75) % 60);
    f.msf_frame_bcd = to_bcd(walk_pos % 75);
    f.sector_lba    = 20'(walk_pos - MsfOffset);
    f.end_ctl       = 4'(walk_endc);
    return f;
  endfunction

  task automatic push_walk(int pos, int trk, int idx, int rel, int ctl, int endc);
    walk_pos  = pos;
    walk_trk  = trk;
    walk_idx  = idx;
    walk_rel  = rel;
    walk_ctl  = ctl;
    walk_endc = endc;
    frames_to_send.push_back(walker_frame());
  endtask

  task automatic reseed_walker();
    walk_pos  = $urandom_range(0, LastPos);
    walk_trk  = (cfg_first <= cfg_last) ? $urandom_range(cfg_first, cfg_last)
                                        : $urandom_range(1, 98);
    walk_idx  = $urandom_range(0, 3);
    walk_rel  = $urandom_range(0, 1000);
    walk_ctl  = $urandom_range(0, 1) ? 0 : 4;
    walk_endc = walk_ctl;
  endtask

  // Mostly a clean read of the disc, with glitches, repeats and raw noise mixed in.
  task automatic next_random_item(output subq_in_t f);
    int kind, ev;
    logic [127:0] raw;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      walk_pos = (walk_pos >= LastPos) ? 0 : walk_pos + 1;
      walk_rel = walk_rel + 1;
      ev = $urandom_range(0, 99);
      if (ev < 4) begin
        walk_trk = (walk_trk >= 99) ? 1 : walk_trk + 1;
        walk_idx = $urandom_range(0, 1);
        walk_rel = 0;
      end else if (ev < 8) begin
        if (walk_idx < 99) walk_idx++;
      end else if (ev < 11) begin
        walk_ctl  = $urandom_range(0, 15);
        walk_endc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : walk_ctl;
      end
      f = walker_frame();
      if (kind < 5) begin
        f.adr = 4'($urandom_range(0, 15));
      end else if (kind >= 72) begin
        // One corrupted field; the pickup itself stays on course.
        case ($urandom_range(0, 5))
          0:       f.track = $urandom_range(0, 1) ? f.track + 7'd1 : f.track - 7'd1;
          1:       f.index_no = $urandom_range(0, 1) ? f.index_no + 7'd1 : f.index_no - 7'd1;
          2:       f.ctl = 4'($urandom_range(0, 15));
          3:       f.rel_time = 19'($urandom);
          4:       f.msf_sec_bcd = 8'($urandom);
          default: f.abs_time = f.abs_time + 19'd2;
        endcase
      end
    end else if (kind < 90) begin
      f = last_frame;
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      f = raw[$bits(subq_in_t)-1:0];
    end
    last_frame = f;
  endtask

  // Call at a rising edge; leaves the write channel valid for a following write.
  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgFirstTrack: cfg_first = val;
      CfgLastTrack:  cfg_last  = val;
      CfgIndexLimit: cfg_limit = val;
      default: ;
    endcase
  endtask

  // Sampled at the falling edge so the clocked processes have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
  endtask

  // Sender: predicts each accepted item, then offers the next one, after a random gap outside quiet phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = judge_frame(in_item);
        verdicts_due.push_back(predicted);
        for (int b = 0; b < 7; b++) if (predicted[b]) flag_hits[b]++;
        prior_ctl = last_ctl;
        prior_trk = last_trk;
        prior_idx = last_idx;
        prior_rel = last_rel;
        last_ctl  = int'(in_item.ctl);
        last_trk  = int'(in_item.track);
        last_idx  = int'(in_item.index_no);
        last_rel  = int'(in_item.rel_time);
        last_abs  = int'(in_item.abs_time);
        sent++;
      end
      // A stalled item stays on the bus unchanged.
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          in_item  <= frames_to_send.pop_front();
          in_valid <= 1'b1;
          if (!quiet_phase) send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted verdict and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= ReportCap) begin
            $display("%0t: verdict %b arrived with none expected", $time, out_item);
          end
        end else begin
          awaited = verdicts_due.pop_front();
          for (int b = 0; b < 7; b++) begin
            if (out_item[b] !== awaited[b]) begin
              errors++;
              if (errors <= ReportCap) begin
                $display("%0t: %s expected %0b, got %0b", $time, verdict_names[b],
                         awaited[b], out_item[b]);
              end
            end
          end
        end
      end
      // One long hold-off while the sender keeps going, so the input side backs up.
      if (!held_off && checked >= 400 && frames_to_send.size() > 20) begin
        held_off  = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_phase) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL subq_sequence_checker");
    $finish;
  end

  initial begin
    subq_in_t f;
    logic [6:0] first_val, last_val, limit_val;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset register values.
    f = '0;
    frames_to_send.push_back(f);
    push_walk(1, 1, 0, 0, 0, 0);
    push_walk(2, 1, 1, 0, 0, 0);               // index zero to one at relative time zero
    push_walk(3, 1, 1, 1, 0, 0);
    push_walk(4, 1, 1, 2, 1, 1);               // control change to the end value mid index
    push_walk(5, 1, 1, 3, 4, 0);               // control change to neither end value nor zero
    push_walk(6, 1, 1, 4, 0, 0);
    push_walk(7, 1, 2, 5, 0, 0);               // index step
    push_walk(8, 2, 1, 0, 0, 0);               // track step with relative time restart
    push_walk(9, 2, 2, 1, 0, 0);
    push_walk(10, 2, 1, 2, 0, 0);              // index falls back: previous one doubtful
    push_walk(11, 2, 1, 3, 0, 0);              // repeated index: the older one doubtful
    push_walk(12, 3, 1, 0, 0, 0);
    push_walk(13, 2, 1, 1, 0, 0);              // track falls back to the older frame's
    push_walk(14, 2, 1, 2, 5, 5);              // control values never used on a disc
    push_walk(15, 2, 1, 3, 15, 15);
    push_walk(16, 2, 1, 4, 0, 0);
    push_walk(17, 2, 0, 5, 0, 0);
    push_walk(18, 2, 1, 6, 0, 0);              // previous index zero, minus one never matches
    push_walk(0, 1, 1, 0, 0, 0);               // lowest LBA
    push_walk(LastPos, 99, 99, LastPos, 11, 15);
    f = '1;
    frames_to_send.push_back(f);
    f = walker_frame();                        // BCD digits above nine
    f.msf_min_bcd   = 8'hFA;
    f.msf_sec_bcd   = 8'h9F;
    f.msf_frame_bcd = 8'hAB;
    frames_to_send.push_back(f);
    f = walker_frame();                        // control change outside current-position mode
    f.adr     = 4'd2;
    f.ctl     = 4'd2;
    f.end_ctl = 4'd2;
    frames_to_send.push_back(f);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph > 0) begin
        wait_idle();
        first_val = first_by_phase[ph];
        last_val  = last_by_phase[ph];
        limit_val = limit_by_phase[ph];
        if (ph == 6) begin
          first_val = 7'($urandom_range(0, 127));
          last_val  = 7'($urandom_range(0, 127));
          limit_val = 7'($urandom_range(0, 127));
        end
        @(posedge clk);
        write_reg(CfgFirstTrack, first_val);
        write_reg(CfgLastTrack, last_val);
        write_reg(CfgIndexLimit, limit_val);
        if (ph == Phases - 1) write_reg(CfgUnused, 7'h55);
        cfg_valid <= 1'b0;
        @(negedge clk);
      end
      quiet_phase = (ph == 2 || ph == 5);
      reseed_walker();
      for (int i = 0; i < ((ph == 0) ? FirstItems : PhaseItems); i++) begin
        next_random_item(f);
        frames_to_send.push_back(f);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
    end
    $display("Sent %0d frames under %0d register settings and checked %0d verdicts.",
             sent, Phases, checked);
    $display("Doubtful flags expected: previous index %0d, older index %0d, track %0d.",
             flag_hits[2], flag_hits[1], flag_hits[0]);
    if (errors == 0) begin
      $display("PASS subq_sequence_checker");
    end else begin
      $display("FAIL subq_sequence_checker");
    end
    $finish;
  end

endmodule
